// File: hdl/hhre_pkg.sv
// ----------------------------------------------------------------------------
// hhre_pkg
// Shared types and constants for the hash hex run escaper: the per-item
// plan passed from the front end to the back end, and character codes.
// ----------------------------------------------------------------------------
package hhre_pkg;

	localparam logic [7:0] HASH_CHAR      = 8'h23;
	localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
	localparam logic [7:0] CTRL_MAX       = 8'h1F;
	localparam logic [7:0] DEL_CHAR       = 8'h7F;
	localparam logic [7:0] DIGIT_ZERO     = 8'h30;
	localparam logic [7:0] LETTER_A       = 8'h41;

	localparam int MAX_BYTES = 4;

	typedef logic [7:0] byte_t;

	// one accepted item worth of output bytes
	typedef struct packed {
		byte_t [MAX_BYTES-1:0] bytes;
		logic [1:0]            cnt_m1;
		logic                  eol;
	} plan_t;

	// upper-case hex digit for one nibble
	function automatic byte_t hex_digit(input logic [3:0] nib);
		byte_t r;
		if (nib < 4'd10) begin
			r = DIGIT_ZERO + {4'd0, nib};
		end else begin
			r = LETTER_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

// File: hdl/hhre_front.sv
// ----------------------------------------------------------------------------
// hhre_front
// Accepts raw bytes, classifies them against the run and backslash state and
// turns each into a plan of one to four output bytes for the queue.
// ----------------------------------------------------------------------------
module hhre_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           data_valid,
	output logic           data_stall,
	input  logic [7:0]     data_byte,
	input  logic           end_of_line,
	input  logic           q_full,
	output logic           push,
	output hhre_pkg::plan_t push_plan
);
	import hhre_pkg::*;

	logic  in_run_q;
	logic  after_bs_q;
	logic  nxt_in_run;
	logic  nxt_after_bs;
	logic  escapable;
	logic [2:0] n;
	plan_t plan;

	assign data_stall = q_full;
	assign push       = data_valid && !q_full;
	assign escapable  = (data_byte == HASH_CHAR) || (data_byte <= CTRL_MAX)
		|| (data_byte >= DEL_CHAR);

	always_comb begin
		plan         = '0;
		n            = 3'd0;
		nxt_in_run   = in_run_q;
		nxt_after_bs = 1'b0;
		if (after_bs_q) begin
			plan.bytes[0] = data_byte;
			n = 3'd1;
		end else if (escapable) begin
			if (!in_run_q) begin
				plan.bytes[n[1:0]] = HASH_CHAR;
				n = n + 3'd1;
			end
			plan.bytes[n[1:0]] = hex_digit(data_byte[7:4]);
			n = n + 3'd1;
			plan.bytes[n[1:0]] = hex_digit(data_byte[3:0]);
			n = n + 3'd1;
			nxt_in_run = 1'b1;
		end else begin
			if (in_run_q) begin
				plan.bytes[n[1:0]] = HASH_CHAR;
				n = n + 3'd1;
			end
			plan.bytes[n[1:0]] = data_byte;
			n = n + 3'd1;
			nxt_in_run   = 1'b0;
			nxt_after_bs = (data_byte == BACKSLASH_CHAR);
		end
		if (end_of_line) begin
			// close any open run at the end of the line
			if (nxt_in_run) begin
				plan.bytes[n[1:0]] = HASH_CHAR;
				n = n + 3'd1;
			end
			nxt_in_run   = 1'b0;
			nxt_after_bs = 1'b0;
		end
		plan.cnt_m1 = 2'(n - 3'd1);
		plan.eol    = end_of_line;
	end

	assign push_plan = plan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q   <= 1'b0;
			after_bs_q <= 1'b0;
		end else if (push) begin
			in_run_q   <= nxt_in_run;
			after_bs_q <= nxt_after_bs;
		end
	end

endmodule

// File: hdl/hhre_queue.sv
// ----------------------------------------------------------------------------
// hhre_queue
// Two-entry plan queue between front and back end so each side can stall
// on its own.
// ----------------------------------------------------------------------------
module hhre_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hhre_pkg::plan_t push_plan,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output hhre_pkg::plan_t head,
	output logic [1:0]     level
);
	import hhre_pkg::*;

	plan_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/hhre_back.sv
// ----------------------------------------------------------------------------
// hhre_back
// Walks the current plan one byte per cycle, unless the output stalls, into
// the output register and fetches the next plan as the last byte goes out.
// ----------------------------------------------------------------------------
module hhre_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  hhre_pkg::plan_t head,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [7:0]     out_byte,
	output logic           last_for_input,
	output logic           line_done
);
	import hhre_pkg::*;

	plan_t      cur_q;
	logic       cur_v_q;
	logic [1:0] idx_q;
	logic       out_v_q;
	byte_t      out_byte_q;
	logic       last_q;
	logic       done_q;
	logic       out_free;
	logic       adv;
	logic       at_last;

	assign out_free = !out_v_q || !result_stall;
	assign adv      = cur_v_q && out_free;
	assign at_last  = (idx_q == cur_q.cnt_m1);
	assign pop      = !q_empty && (!cur_v_q || (adv && at_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (adv) begin
			out_byte_q <= cur_q.bytes[idx_q];
			last_q     <= at_last;
			done_q     <= at_last && cur_q.eol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_v_q <= 1'b1;
				idx_q   <= 2'd0;
			end else if (adv) begin
				if (at_last) begin
					cur_v_q <= 1'b0;
					idx_q   <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (out_free) begin
				out_v_q <= adv;
			end
		end
	end

	assign result_valid   = out_v_q;
	assign out_byte       = out_byte_q;
	assign last_for_input = last_q;
	assign line_done      = done_q;

endmodule

// File: hdl/hash_hex_run_escaper_unit.sv
// ----------------------------------------------------------------------------
// hash_hex_run_escaper_unit
// Escapes a line of bytes: non-printable bytes and '#' become '#'-delimited
// runs of upper-case hex digits, a backslash carries the next byte through.
//
// Input channel data_valid/data_stall carries data_byte and end_of_line.
// Output channel result_valid/result_stall carries out_byte, last_for_input
// and line_done; each input item gives one to four result items.
// The front end classifies an item in the cycle it is accepted and queues a
// plan; a plan then passes through the queue and the current-plan register,
// and each of its bytes through the output register. Throughput is one
// result byte per cycle while the receiver does not stall, as set by the
// single-byte result channel; the two-entry plan queue absorbs the
// difference. If the receiver stalls, the output register holds and the
// queue fills, after which data_stall rises. Reset clears the run and
// backslash state, empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module hash_hex_run_escaper_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_line,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       last_for_input,
	output logic       line_done
);
	import hhre_pkg::*;

	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	logic [1:0] q_level;
	plan_t      push_plan;
	plan_t      head;

	hhre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_byte   (data_byte),
		.end_of_line (end_of_line),
		.q_full      (q_full),
		.push        (push),
		.push_plan   (push_plan)
	);

	hhre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (push_plan),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head),
		.level     (q_level)
	);

	hhre_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.last_for_input (last_for_input),
		.line_done      (line_done)
	);

`ifndef SYNTH
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level != 2'd3)
		else $error("plan queue level out of range");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && line_done |-> last_for_input)
		else $error("line_done without last_for_input");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty plan queue");

	a_push_level: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && q_level == 2'd0 |=> q_level == 2'd1)
		else $error("plan queue level did not follow push");
`endif

endmodule
